@@ hdl/rlbc_pkg.sv @@
// Shared types and constants for the reference-counted LRU block cache.
// No dependencies; used by the top level and its checker.
package rlbc_pkg;

  localparam int ENTRIES = 256;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int LINK_W  = IDX_W + 1;
  localparam int BLK_W   = 48;
  localparam int CNT_W   = 16;

  localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(ENTRIES);

  localparam logic [1:0] OP_ACQUIRE  = 2'd0;
  localparam logic [1:0] OP_RELEASE  = 2'd1;
  localparam logic [1:0] OP_DIRTY    = 2'd2;
  localparam logic [1:0] OP_COMPLETE = 2'd3;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_BUSY  = 2'd1;
  localparam logic [1:0] STS_COUNT = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_LOOK, S_EXEC, S_UNLINK, S_PUSH1, S_PUSH2, S_FIN
  } state_t;

  typedef struct packed {
    logic             ready;
    logic             dirty;
    logic [CNT_W-1:0] cnt;
    logic             on_lru;
  } meta_t;

  localparam meta_t META_RST = '{ready: 1'b0, dirty: 1'b0, cnt: '0, on_lru: 1'b1};

  function automatic logic [LINK_W-1:0] rst_prev(input logic [IDX_W-1:0] a);
    rst_prev = (a == '0) ? LINK_NONE : LINK_W'(a) - LINK_W'(1);
  endfunction

  function automatic logic [LINK_W-1:0] rst_next(input logic [IDX_W-1:0] a);
    rst_next = (a == IDX_W'(ENTRIES - 1)) ? LINK_NONE : LINK_W'(a) + LINK_W'(1);
  endfunction

endpackage

@@ hdl/refcounted_lru_block_cache.sv @@
// Reference-counted LRU block cache tag store: lookup, pinning and LRU list.
// Depends on rlbc_pkg.
//
// Usage: one request beat enters on in_* (tuser = operation, tdata = block
// number, entry index, I/O success) and one result beat leaves on out_*.
// Acquire scans the tag memory one entry per cycle; a hit ends the scan early.
// Release, mark dirty and completion read the entry memories in S_LOOK, do a
// read-modify-write in S_EXEC, write the LRU links in S_PUSH1 and S_PUSH2 when
// the entry returns to the list (each link memory has a single write port),
// then present the result in S_FIN.
// One request is in flight at a time; the next request beat is taken in the
// cycle after the result is registered, also while that result beat still waits.
// Reset starts a clearing pass that writes reset values into the entry
// memories, one entry per cycle; in_tready stays low until the pass ends.
// When the receiver stalls, the result holds in the output register; a
// following request runs until its own result is ready and then waits.
module refcounted_lru_block_cache (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // block_number[47:0], entry_index[55:48], io_success[56]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // status[1:0], entry[9:2], hit[10], ready_res[11],
                                  // issue_read[12], issue_write[13], io_block[61:14],
                                  // wake_waiters[62]
);

  localparam int N  = rlbc_pkg::ENTRIES;
  localparam int IW = rlbc_pkg::IDX_W;
  localparam int LW = rlbc_pkg::LINK_W;
  localparam int BW = rlbc_pkg::BLK_W;
  localparam int CW = rlbc_pkg::CNT_W;

  logic [BW-1:0]       tag_mem  [N];
  rlbc_pkg::meta_t     meta_mem [N];
  logic [LW-1:0]       prev_mem [N];
  logic [LW-1:0]       next_mem [N];
  logic [N-1:0]        valid_r;
  logic [IW:0]         clr_r;
  logic                clr_busy;

  rlbc_pkg::state_t st_r, st_nxt, exec_go;

  logic [1:0]    op_r;
  logic [BW-1:0] bn_r;
  logic          ok_r;
  logic [IW-1:0] tgt_r;
  logic [LW-1:0] scan_r;
  logic          chk_r;
  logic [LW-1:0] head_r, tail_r, head_nxt, tail_nxt, lp_r, ln_r;

  logic [1:0]    status_r, status_nxt;
  logic [IW-1:0] entry_r;
  logic          hit_r, rdy_r, rdy_nxt, rd_r, rd_nxt, wr_r, wr_nxt, wake_r, wake_nxt;
  logic [BW-1:0] blk_r, blk_nxt;

  logic            out_valid_r;
  logic [63:0]     out_data_r;

  logic [IW-1:0]   rd_addr, addr_q;
  logic [BW-1:0]   tag_q;
  rlbc_pkg::meta_t meta_q, meta_d, meta_wd;
  logic [LW-1:0]   prev_q, next_q, prev_d, next_d;
  logic            vq;

  logic            tag_we, meta_we, prev_we, next_we;
  logic [IW-1:0]   prev_wa, next_wa;
  logic [LW-1:0]   prev_wd, next_wd;
  logic            found, miss;

  assign clr_busy   = !clr_r[IW];
  assign in_tready  = (st_r == rlbc_pkg::S_IDLE) && !clr_busy;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign rd_addr = (st_r == rlbc_pkg::S_SCAN) ? scan_r[IW-1:0] : tgt_r;

  always_ff @(posedge clk) begin
    tag_q   <= tag_mem[rd_addr];
    meta_q  <= meta_mem[rd_addr];
    prev_q  <= prev_mem[rd_addr];
    next_q  <= next_mem[rd_addr];
    vq      <= valid_r[rd_addr];
    addr_q  <= rd_addr;
    if (tag_we) begin
      tag_mem[tgt_r] <= bn_r;
    end
    if (clr_busy) begin
      meta_mem[clr_r[IW-1:0]] <= rlbc_pkg::META_RST;
      prev_mem[clr_r[IW-1:0]] <= rlbc_pkg::rst_prev(clr_r[IW-1:0]);
      next_mem[clr_r[IW-1:0]] <= rlbc_pkg::rst_next(clr_r[IW-1:0]);
    end else begin
      if (meta_we) begin
        meta_mem[tgt_r] <= meta_wd;
      end
      if (prev_we) begin
        prev_mem[prev_wa] <= prev_wd;
      end
      if (next_we) begin
        next_mem[next_wa] <= next_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      clr_r   <= '0;
    end else begin
      if (tag_we) valid_r[tgt_r] <= 1'b1;
      if (clr_busy) clr_r <= clr_r + (IW+1)'(1);
    end
  end

  assign meta_d = meta_q;
  assign prev_d = prev_q;
  assign next_d = next_q;
  assign found  = chk_r && vq && (tag_q == bn_r);
  assign miss   = !found && !chk_r && (scan_r == LW'(N));

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      rlbc_pkg::S_IDLE: begin
        if (in_tvalid && in_tready) begin
          st_nxt = (in_tuser == rlbc_pkg::OP_ACQUIRE) ? rlbc_pkg::S_SCAN : rlbc_pkg::S_LOOK;
        end
      end
      rlbc_pkg::S_SCAN: begin
        if (found) st_nxt = rlbc_pkg::S_LOOK;
        else if (miss) begin
          st_nxt = (tail_r == rlbc_pkg::LINK_NONE) ? rlbc_pkg::S_FIN : rlbc_pkg::S_LOOK;
        end
      end
      rlbc_pkg::S_LOOK:   st_nxt = rlbc_pkg::S_EXEC;
      rlbc_pkg::S_EXEC:   st_nxt = exec_go;
      rlbc_pkg::S_UNLINK: st_nxt = rlbc_pkg::S_FIN;
      rlbc_pkg::S_PUSH1:  st_nxt = rlbc_pkg::S_PUSH2;
      rlbc_pkg::S_PUSH2:  st_nxt = rlbc_pkg::S_FIN;
      rlbc_pkg::S_FIN: begin
        if (!out_valid_r || out_tready) st_nxt = rlbc_pkg::S_IDLE;
      end
      default: st_nxt = rlbc_pkg::S_IDLE;
    endcase
  end

  // Memory writes and result values
  always_comb begin
    rlbc_pkg::meta_t m;
    m          = meta_d;
    exec_go    = rlbc_pkg::S_FIN;
    tag_we     = 1'b0;
    meta_we    = 1'b0;
    meta_wd    = meta_d;
    prev_we    = 1'b0;
    prev_wa    = tgt_r;
    prev_wd    = rlbc_pkg::LINK_NONE;
    next_we    = 1'b0;
    next_wa    = tgt_r;
    next_wd    = head_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    status_nxt = status_r;
    rdy_nxt    = rdy_r;
    rd_nxt     = rd_r;
    wr_nxt     = wr_r;
    blk_nxt    = blk_r;
    wake_nxt   = wake_r;
    case (st_r)
      rlbc_pkg::S_IDLE: begin
        status_nxt = rlbc_pkg::STS_OK;
        rdy_nxt    = 1'b0;
        rd_nxt     = 1'b0;
        wr_nxt     = 1'b0;
        blk_nxt    = '0;
        wake_nxt   = 1'b0;
      end
      rlbc_pkg::S_SCAN: begin
        if (miss && tail_r == rlbc_pkg::LINK_NONE) status_nxt = rlbc_pkg::STS_BUSY;
      end
      rlbc_pkg::S_EXEC: begin
        case (op_r)
          rlbc_pkg::OP_ACQUIRE: begin
            if (hit_r) begin
              rdy_nxt = meta_d.ready;
              if (meta_d.cnt == rlbc_pkg::CNT_MAX) begin
                status_nxt = rlbc_pkg::STS_COUNT;
              end else begin
                m.cnt    = meta_d.cnt + CW'(1);
                m.on_lru = 1'b0;
                meta_we  = 1'b1;
                meta_wd  = m;
                if (meta_d.on_lru) exec_go = rlbc_pkg::S_UNLINK;
              end
            end else begin
              tag_we  = 1'b1;
              meta_we = 1'b1;
              meta_wd = '{ready: 1'b0, dirty: 1'b0, cnt: CW'(1), on_lru: 1'b0};
              rd_nxt  = 1'b1;
              blk_nxt = bn_r;
              exec_go = rlbc_pkg::S_UNLINK;
            end
          end
          default: begin
            if (op_r == rlbc_pkg::OP_DIRTY) m.dirty = 1'b1;
            if (op_r == rlbc_pkg::OP_COMPLETE) begin
              m.ready  = m.ready | ok_r;
              wake_nxt = 1'b1;
            end
            if (op_r == rlbc_pkg::OP_RELEASE || (op_r == rlbc_pkg::OP_COMPLETE && m.dirty)) begin
              if (op_r == rlbc_pkg::OP_COMPLETE) m.dirty = 1'b0;
              if (m.cnt == '0) begin
                status_nxt = rlbc_pkg::STS_COUNT;
              end else if (m.cnt != CW'(1)) begin
                m.cnt = m.cnt - CW'(1);
              end else if (!m.dirty) begin
                m.cnt = '0;
                if (!m.on_lru) begin
                  m.on_lru = 1'b1;
                  exec_go  = rlbc_pkg::S_PUSH1;
                end
              end else begin
                m.ready = 1'b0;
                wr_nxt  = 1'b1;
                blk_nxt = tag_q;
              end
            end
            meta_we = 1'b1;
            meta_wd = m;
            rdy_nxt = m.ready;
          end
        endcase
      end
      rlbc_pkg::S_UNLINK: begin
        if (lp_r < rlbc_pkg::LINK_NONE) begin
          next_we = 1'b1;
          next_wa = lp_r[IW-1:0];
          next_wd = ln_r;
        end else begin
          head_nxt = ln_r;
        end
        if (ln_r < rlbc_pkg::LINK_NONE) begin
          prev_we = 1'b1;
          prev_wa = ln_r[IW-1:0];
          prev_wd = lp_r;
        end else begin
          tail_nxt = lp_r;
        end
      end
      rlbc_pkg::S_PUSH1: begin
        next_we = 1'b1;
        next_wa = tgt_r;
        next_wd = head_r;
        if (head_r < rlbc_pkg::LINK_NONE) begin
          prev_we = 1'b1;
          prev_wa = head_r[IW-1:0];
          prev_wd = LW'(tgt_r);
        end else begin
          tail_nxt = LW'(tgt_r);
        end
      end
      rlbc_pkg::S_PUSH2: begin
        prev_we  = 1'b1;
        prev_wa  = tgt_r;
        prev_wd  = rlbc_pkg::LINK_NONE;
        head_nxt = LW'(tgt_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= rlbc_pkg::S_IDLE;
      head_r      <= '0;
      tail_r      <= LW'(N - 1);
      out_valid_r <= 1'b0;
      chk_r       <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= (out_valid_r && !out_tready) ||
                     (st_r == rlbc_pkg::S_FIN && (!out_valid_r || out_tready));
      chk_r       <= (st_r == rlbc_pkg::S_SCAN) && (scan_r < LW'(N)) && !found;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    rdy_r    <= rdy_nxt;
    rd_r     <= rd_nxt;
    wr_r     <= wr_nxt;
    blk_r    <= blk_nxt;
    wake_r   <= wake_nxt;
    case (st_r)
      rlbc_pkg::S_IDLE: begin
        op_r     <= in_tuser;
        bn_r     <= in_tdata[BW-1:0];
        tgt_r    <= in_tdata[55:48];
        entry_r  <= in_tdata[55:48];
        ok_r     <= in_tdata[56];
        scan_r   <= '0;
        hit_r    <= 1'b0;
      end
      rlbc_pkg::S_SCAN: begin
        if (scan_r < LW'(N) && !found) scan_r <= scan_r + LW'(1);
        if (found) begin
          hit_r   <= 1'b1;
          tgt_r   <= addr_q;
          entry_r <= addr_q;
        end else if (miss) begin
          if (tail_r == rlbc_pkg::LINK_NONE) begin
            entry_r  <= '0;
          end else begin
            tgt_r   <= tail_r[IW-1:0];
            entry_r <= tail_r[IW-1:0];
          end
        end
      end
      rlbc_pkg::S_EXEC: begin
        lp_r <= prev_d;
        ln_r <= next_d;
      end
      rlbc_pkg::S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_data_r <= {1'b0, wake_r, blk_r, wr_r, rd_r, rdy_r, hit_r, entry_r, status_r};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/rlbc_checker.sv @@
// Port-level checks for the reference-counted LRU block cache.
// Depends on rlbc_pkg; bound to refcounted_lru_block_cache.
module rlbc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == rlbc_pkg::STS_BUSY |->
      out_tdata[9:2] == '0 && out_tdata[13:10] == '0 && out_tdata[62] == 1'b0)
    else $error("busy result carries flags");

  a_rdwr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[12] |-> !out_tdata[13] && !out_tdata[10] && !out_tdata[62])
    else $error("read request mixed with other outcomes");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("beat offered right after reset");

endmodule

bind refcounted_lru_block_cache rlbc_checker u_rlbc_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

@@ tb/sv/tb_refcounted_lru_block_cache.sv @@
// Self-checking testbench for refcounted_lru_block_cache: a tag-store predictor
// scores every result beat against queued expectations. Depends on rlbc_pkg.
module tb_refcounted_lru_block_cache;

  localparam int ENTRIES = rlbc_pkg::ENTRIES;
  localparam int IDX_W   = rlbc_pkg::IDX_W;
  localparam int BLK_W   = rlbc_pkg::BLK_W;
  localparam logic [rlbc_pkg::CNT_W-1:0] CNT_MAX = rlbc_pkg::CNT_MAX;
  localparam logic [1:0] OP_ACQUIRE  = rlbc_pkg::OP_ACQUIRE;
  localparam logic [1:0] OP_RELEASE  = rlbc_pkg::OP_RELEASE;
  localparam logic [1:0] OP_DIRTY    = rlbc_pkg::OP_DIRTY;
  localparam logic [1:0] OP_COMPLETE = rlbc_pkg::OP_COMPLETE;
  localparam logic [1:0] STS_OK      = rlbc_pkg::STS_OK;
  localparam logic [1:0] STS_BUSY    = rlbc_pkg::STS_BUSY;
  localparam logic [1:0] STS_COUNT   = rlbc_pkg::STS_COUNT;

  localparam int NONE       = ENTRIES;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] entry;
    logic             hit;
    logic             rdy;
    logic             rd;
    logic             wr;
    logic [BLK_W-1:0] blk;
    logic             wake;
  } cache_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;

  refcounted_lru_block_cache u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // tag store shadow
  logic [BLK_W-1:0] m_tag [ENTRIES];
  bit               m_valid [ENTRIES];
  bit               m_ready [ENTRIES];
  bit               m_dirty [ENTRIES];
  bit               m_on [ENTRIES];
  int               m_cnt [ENTRIES];
  int               m_prev [ENTRIES];
  int               m_next [ENTRIES];
  int               m_head;
  int               m_tail;

  cache_res_t       expect_q[$];
  int               held_q[$];
  logic [BLK_W-1:0] blk_pool [48];
  int               errors = 0;
  int               beats_in = 0;
  int               beats_out = 0;
  int               busy_seen = 0;
  int               count_err_seen = 0;
  int               burst_left = 0;
  bit               steady = 1'b0;
  bit               hold_req = 1'b0;
  int               hold_left = 0;
  int               idle_cycles = 0;
  int               rx_cycle = 0;

  function automatic void cache_reset();
    for (int i = 0; i < ENTRIES; i++) begin
      m_tag[i] = '0;
      m_valid[i] = 0;
      m_ready[i] = 0;
      m_dirty[i] = 0;
      m_cnt[i] = 0;
      m_on[i] = 1;
      m_prev[i] = (i == 0) ? NONE : i - 1;
      m_next[i] = (i == ENTRIES - 1) ? NONE : i + 1;
    end
    m_head = 0;
    m_tail = ENTRIES - 1;
  endfunction

  function automatic void lru_drop(input int i);
    int p, n;
    if (!m_on[i]) return;
    p = m_prev[i];
    n = m_next[i];
    if (p < ENTRIES) m_next[p] = n;
    else m_head = n;
    if (n < ENTRIES) m_prev[n] = p;
    else m_tail = p;
    m_on[i] = 0;
    m_prev[i] = NONE;
    m_next[i] = NONE;
  endfunction

  function automatic void lru_front(input int i);
    if (m_on[i]) return;
    m_prev[i] = NONE;
    m_next[i] = m_head;
    if (m_head < ENTRIES) m_prev[m_head] = i;
    else m_tail = i;
    m_head = i;
    m_on[i] = 1;
  endfunction

  function automatic logic [1:0] unpin(input int i, inout logic wr,
                                       inout logic [BLK_W-1:0] blk);
    if (m_cnt[i] == 0) return STS_COUNT;
    m_cnt[i]--;
    if (m_cnt[i] != 0) return STS_OK;
    if (!m_dirty[i]) begin
      lru_front(i);
      return STS_OK;
    end
    m_cnt[i] = 1;
    m_ready[i] = 0;
    wr = 1'b1;
    blk = m_tag[i];
    return STS_OK;
  endfunction

  function automatic cache_res_t cache_step(input logic [1:0] op,
                                            input logic [BLK_W-1:0] bn,
                                            input logic [IDX_W-1:0] idx,
                                            input logic ok);
    cache_res_t r;
    int found, i;
    r = '0;
    r.entry = idx;
    found = NONE;
    if (op == OP_ACQUIRE) begin
      for (int k = 0; k < ENTRIES; k++)
        if (found == NONE && m_valid[k] && m_tag[k] == bn) found = k;
      if (found != NONE) begin
        r.hit = 1'b1;
        r.entry = IDX_W'(found);
        if (m_cnt[found] >= int'(CNT_MAX)) r.status = STS_COUNT;
        else begin
          lru_drop(found);
          m_cnt[found]++;
        end
        r.rdy = m_ready[found];
      end else if (m_tail >= ENTRIES) begin
        r.status = STS_BUSY;
        r.entry = '0;
      end else begin
        i = m_tail;
        lru_drop(i);
        m_tag[i] = bn;
        m_valid[i] = 1;
        m_ready[i] = 0;
        m_dirty[i] = 0;
        m_cnt[i] = 1;
        r.entry = IDX_W'(i);
        r.rd = 1'b1;
        r.blk = bn;
      end
    end else begin
      i = int'(idx);
      if (op == OP_RELEASE) r.status = unpin(i, r.wr, r.blk);
      else if (op == OP_DIRTY) m_dirty[i] = 1;
      else begin
        if (ok) m_ready[i] = 1;
        r.wake = 1'b1;
        if (m_dirty[i]) begin
          m_dirty[i] = 0;
          r.status = unpin(i, r.wr, r.blk);
        end
      end
      r.rdy = m_ready[i];
    end
    return r;
  endfunction

  task automatic send_req(input logic [1:0] op, input logic [BLK_W-1:0] bn,
                          input logic [IDX_W-1:0] idx, input logic ok);
    cache_res_t r;
    if (!steady && burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(4) == 0) ? 60 : $urandom_range(1, 20);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'b0, ok, idx, bn};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    beats_in++;
    r = cache_step(op, bn, idx, ok);
    if (r.status == STS_BUSY) busy_seen++;
    if (r.status == STS_COUNT) count_err_seen++;
    if (op == OP_ACQUIRE && r.status == STS_OK) held_q.push_back(int'(r.entry));
    expect_q.push_back(r);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_req(OP_ACQUIRE, 48'h0, 8'h00, 1'b0);
    send_req(OP_ACQUIRE, {BLK_W{1'b1}}, 8'hff, 1'b1);
    send_req(OP_ACQUIRE, 48'h0, 8'h00, 1'b0);
    send_req(OP_COMPLETE, 48'h0, 8'd255, 1'b1);
    send_req(OP_COMPLETE, 48'h0, 8'd254, 1'b0);
    send_req(OP_DIRTY, 48'h0, 8'd255, 1'b0);
    send_req(OP_RELEASE, 48'h0, 8'd255, 1'b0);
    send_req(OP_RELEASE, 48'h0, 8'd255, 1'b0);
    send_req(OP_COMPLETE, 48'h0, 8'd255, 1'b1);
    send_req(OP_RELEASE, 48'h0, 8'd255, 1'b0);
    send_req(OP_RELEASE, 48'h0, 8'd254, 1'b0);
    send_req(OP_DIRTY, 48'h0, 8'd254, 1'b0);
    send_req(OP_COMPLETE, 48'h0, 8'd254, 1'b0);
    send_req(OP_COMPLETE, 48'h0, 8'd10, 1'b1);
    send_req(OP_COMPLETE, 48'h0, 8'd0, 1'b0);
    send_req(OP_ACQUIRE, {BLK_W{1'b1}}, 8'h00, 1'b0);
    send_req(OP_ACQUIRE, 48'h0, 8'h00, 1'b0);
    send_req(OP_RELEASE, 48'h0, 8'd255, 1'b0);
    send_req(OP_RELEASE, 48'h0, 8'd254, 1'b0);
    drain();
    held_q.delete();
  endtask

  // pin every entry, ask for more, then unpin everything
  task automatic test_exhaust();
    logic [BLK_W-1:0] nb;
    nb = 48'h5000_0000_0000;
    while (m_tail != NONE) begin
      send_req(OP_ACQUIRE, nb, 8'h00, 1'b0);
      nb++;
    end
    send_req(OP_ACQUIRE, nb, 8'h00, 1'b0);
    send_req(OP_ACQUIRE, nb + 1, 8'h00, 1'b0);
    drain();
    for (int i = 0; i < ENTRIES; i++)
      while (m_cnt[i] > 0)
        if (m_dirty[i]) send_req(OP_COMPLETE, 48'h0, IDX_W'(i), 1'b1);
        else send_req(OP_RELEASE, 48'h0, IDX_W'(i), 1'b0);
    drain();
    held_q.delete();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    steady = 1'b1;
    for (int k = 0; k < 8; k++)
      send_req(OP_ACQUIRE, blk_pool[k], 8'h00, 1'b0);
    steady = 1'b0;
    drain();
  endtask

  task automatic test_random(input int n);
    int r, pick, idx, start;
    logic [BLK_W-1:0] bn;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      bn = BLK_W'({$urandom, $urandom});
      idx = $urandom_range(ENTRIES - 1);
      if (r < 40) begin
        if ($urandom_range(3) != 0) bn = blk_pool[$urandom_range(47)];
        send_req(OP_ACQUIRE, bn, 8'h00, 1'($urandom_range(1)));
      end else if (r < 72) begin
        if (held_q.size() != 0 && $urandom_range(9) != 0) begin
          pick = $urandom_range(held_q.size() - 1);
          idx = held_q[pick];
          held_q.delete(pick);
        end
        send_req(OP_RELEASE, bn, IDX_W'(idx), 1'($urandom_range(1)));
      end else if (r < 82) begin
        if (held_q.size() != 0 && $urandom_range(3) != 0)
          idx = held_q[$urandom_range(held_q.size() - 1)];
        send_req(OP_DIRTY, bn, IDX_W'(idx), 1'($urandom_range(1)));
      end else begin
        if ($urandom_range(4) != 0) begin
          start = $urandom_range(ENTRIES - 1);
          idx = start;
          for (int j = 0; j < ENTRIES; j++)
            if (idx == start + 0 && m_valid[(start + j) % ENTRIES] &&
                (!m_ready[(start + j) % ENTRIES] || m_dirty[(start + j) % ENTRIES]))
              idx = ((start + j) % ENTRIES) + ENTRIES;
          idx = idx % ENTRIES;
        end
        send_req(OP_COMPLETE, bn, IDX_W'(idx), $urandom_range(3) != 0);
      end
      if (k == n / 2) drain();
    end
    drain();
  endtask

  always @(posedge clk) begin
    rx_cycle++;
    if (hold_req) begin
      hold_left = 600;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (steady || (rx_cycle / 64) % 3 == 0) begin
      out_tready <= 1'b1;
    end else if ((rx_cycle / 64) % 3 == 1) begin
      out_tready <= ($urandom_range(3) != 0);
    end else begin
      out_tready <= (rx_cycle % 5 != 0);
    end
  end

  task automatic check_field(input string name, input logic [BLK_W-1:0] exp_v,
                             input logic [BLK_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    cache_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      beats_out++;
      if (expect_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0h", $time, out_tdata);
        errors++;
      end else begin
        e = expect_q.pop_front();
        check_field("status", BLK_W'(e.status), BLK_W'(out_tdata[1:0]));
        check_field("entry", BLK_W'(e.entry), BLK_W'(out_tdata[9:2]));
        check_field("hit", BLK_W'(e.hit), BLK_W'(out_tdata[10]));
        check_field("ready_res", BLK_W'(e.rdy), BLK_W'(out_tdata[11]));
        check_field("issue_read", BLK_W'(e.rd), BLK_W'(out_tdata[12]));
        check_field("issue_write", BLK_W'(e.wr), BLK_W'(out_tdata[13]));
        check_field("io_block", e.blk, out_tdata[61:14]);
        check_field("wake_waiters", BLK_W'(e.wake), BLK_W'(out_tdata[62]));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    cache_reset();
    for (int k = 0; k < 48; k++)
      blk_pool[k] = (k < 24) ? BLK_W'(k) : BLK_W'({$urandom, $urandom});
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_exhaust();
    test_backpressure();
    test_random(760);
    repeat (300) @(posedge clk);
    if (expect_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expect_q.size());
      errors++;
    end
    $display("Sent %0d requests, checked %0d results (%0d all-busy, %0d count errors).",
             beats_in, beats_out, busy_seen, count_err_seen);
    $display("Covered hits, misses, write-backs, completions, exhaustion and backpressure.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/rlbc_pkg.sv
hdl/refcounted_lru_block_cache.sv
hdl/rlbc_checker.sv
tb/sv/tb_refcounted_lru_block_cache.sv
